@@ hw/rtl/imu_acc_pkg.sv @@
// shared types, constants and control codes for the imu sample accumulator
`timescale 1ns / 1ps
package imu_acc_pkg;

    localparam logic [15:0] PERIOD_RESET    = 16'd19000;
    localparam logic [31:0] VALID_WINDOW_US = 32'd500;
    localparam logic [7:0]  COUNT_MAX       = 8'd255;
    localparam int          NUM_AXES        = 3;
    localparam int          NUM_AVG         = 2 * NUM_AXES;
    localparam int          AVG_IDX_W       = $clog2(NUM_AVG);
    localparam int          STEP_W          = 4;
    localparam int          DIV_ITER        = 16;
    localparam int          DIV_CNT_W       = $clog2(DIV_ITER);

    typedef struct packed {
        logic               cmd;
        logic [31:0]        time_us;
        logic               bus_granted;
        logic signed [15:0] word_first;
        logic signed [15:0] word_second;
        logic signed [15:0] word_third;
    } t_in_item;

    typedef struct packed {
        logic               read_done;
        logic               read_was_gyro;
        logic signed [15:0] accel_avg_x;
        logic signed [15:0] accel_avg_y;
        logic signed [15:0] accel_avg_z;
        logic signed [15:0] gyro_avg_x;
        logic signed [15:0] gyro_avg_y;
        logic signed [15:0] gyro_avg_z;
        logic               data_valid;
        logic               fresh_available;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_POLL,
        OP_DIV_START,
        OP_STORE_AVG,
        OP_CLEAR,
        OP_VALID,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_IS_FETCH,
        COND_NOT_FRESH,
        COND_DIV_BUSY,
        COND_MORE_AXES,
        COND_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              seq_end;
    } t_ucode;

    typedef struct packed {
        logic in_valid;
        logic is_fetch;
        logic fresh;
        logic div_busy;
        logic more_axes;
        logic out_full;
    } t_flags;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [7:0]  divisor;
    } t_div_req;

endpackage

@@ hw/rtl/imu_acc_in_if.sv @@
// valid/ready channel carrying poll and fetch items
`timescale 1ns / 1ps
interface imu_acc_in_if
    import imu_acc_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/imu_acc_out_if.sv @@
// valid/ready channel carrying result items
`timescale 1ns / 1ps
interface imu_acc_out_if
    import imu_acc_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/imu_acc_div.sv @@
// iterative signed sum by count divider, one quotient bit per cycle
`timescale 1ns / 1ps
module imu_acc_div
    import imu_acc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_busy,
    output logic signed [15:0] o_quot
);
    logic [31:0]          w_mag;
    logic [8:0]           w_trial;
    logic                 w_ge;
    logic [7:0]           r_rem;
    logic [15:0]          r_q;
    logic [7:0]           r_div;
    logic                 r_neg;
    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;

    // |sum| <= count * 32768, so the top byte is already below the divisor
    assign w_mag   = i_req.dividend[31] ? (~i_req.dividend + 32'd1) : i_req.dividend;
    assign w_trial = {r_rem, r_q[15]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= w_mag[23:16];
            r_q    <= w_mag[15:0];
            r_div  <= i_req.divisor;
            r_neg  <= i_req.dividend[31];
        end else if (r_busy) begin
            r_rem <= w_ge ? 8'(w_trial - {1'b0, r_div}) : w_trial[7:0];
            r_q   <= {r_q[14:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // magnitude tops out at 32768: clamp it on the positive side
    always_comb begin
        if (r_neg) begin
            o_quot = ~r_q + 16'd1;
        end else if (r_q[15]) begin
            o_quot = 16'h7FFF;
        end else begin
            o_quot = r_q;
        end
    end

    assign o_busy = r_busy;

    a_div_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider did not go busy after start");

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("divider restarted while busy");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("partial remainder reached the divisor");
endmodule

@@ hw/rtl/imu_acc_seq.sv @@
// microcode store and step counter driving the accumulator datapath
`timescale 1ns / 1ps
module imu_acc_seq
    import imu_acc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ucode o_ctrl
);
    localparam logic [STEP_W-1:0] S_WAIT      = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH  = 4'd1;
    localparam logic [STEP_W-1:0] S_POLL      = 4'd2;
    localparam logic [STEP_W-1:0] S_FCHK      = 4'd3;
    localparam logic [STEP_W-1:0] S_DIV_START = 4'd4;
    localparam logic [STEP_W-1:0] S_DIV_WAIT  = 4'd5;
    localparam logic [STEP_W-1:0] S_DIV_STORE = 4'd6;
    localparam logic [STEP_W-1:0] S_CLEAR     = 4'd7;
    localparam logic [STEP_W-1:0] S_VALID     = 4'd8;
    localparam logic [STEP_W-1:0] S_EMIT      = 4'd9;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              w_take;

    function automatic t_ucode ucode_rom(input logic [STEP_W-1:0] step);
        t_ucode w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: S_WAIT, seq_end: 1'b0};
        case (step)
            S_WAIT:      w = '{op: OP_ACCEPT,    cond: COND_NO_INPUT,  target: S_WAIT,
                               seq_end: 1'b0};
            S_DISPATCH:  w = '{op: OP_NOP,       cond: COND_IS_FETCH,  target: S_FCHK,
                               seq_end: 1'b0};
            S_POLL:      w = '{op: OP_POLL,      cond: COND_ALWAYS,    target: S_EMIT,
                               seq_end: 1'b0};
            S_FCHK:      w = '{op: OP_NOP,       cond: COND_NOT_FRESH, target: S_VALID,
                               seq_end: 1'b0};
            S_DIV_START: w = '{op: OP_DIV_START, cond: COND_NEVER,     target: S_WAIT,
                               seq_end: 1'b0};
            S_DIV_WAIT:  w = '{op: OP_NOP,       cond: COND_DIV_BUSY,  target: S_DIV_WAIT,
                               seq_end: 1'b0};
            S_DIV_STORE: w = '{op: OP_STORE_AVG, cond: COND_MORE_AXES, target: S_DIV_START,
                               seq_end: 1'b0};
            S_CLEAR:     w = '{op: OP_CLEAR,     cond: COND_NEVER,     target: S_WAIT,
                               seq_end: 1'b0};
            S_VALID:     w = '{op: OP_VALID,     cond: COND_NEVER,     target: S_WAIT,
                               seq_end: 1'b0};
            S_EMIT:      w = '{op: OP_EMIT,      cond: COND_OUT_FULL,  target: S_EMIT,
                               seq_end: 1'b1};
            default:     w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: S_WAIT,
                               seq_end: 1'b0};
        endcase
        return w;
    endfunction

    assign o_ctrl = ucode_rom(r_step);

    always_comb begin
        case (o_ctrl.cond)
            COND_NEVER:     w_take = 1'b0;
            COND_ALWAYS:    w_take = 1'b1;
            COND_NO_INPUT:  w_take = !i_flags.in_valid;
            COND_IS_FETCH:  w_take = i_flags.is_fetch;
            COND_NOT_FRESH: w_take = !i_flags.fresh;
            COND_DIV_BUSY:  w_take = i_flags.div_busy;
            COND_MORE_AXES: w_take = i_flags.more_axes;
            COND_OUT_FULL:  w_take = i_flags.out_full;
            default:        w_take = 1'b1;
        endcase
        if (w_take) begin
            n_step = o_ctrl.target;
        end else if (o_ctrl.seq_end) begin
            n_step = S_WAIT;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end
endmodule

@@ hw/rtl/imu_alternating_sample_accumulator.sv @@
// top level: accelerometer/gyro sample accumulator with averaged fetch
// a poll registers its result after the input transfer, through the poll and emit steps; a fetch
// with both counts nonzero runs the bit-serial divider first (start, 16 steps, settle and store
// per axis, six axes in turn), then clears the sums and counts and emits; a fetch with an empty
// count skips division and clearing; one item at a time, a stalled result holds emit
// synchronous active-low reset clears sums, counts, stage and stamps
`timescale 1ns / 1ps
module imu_alternating_sample_accumulator
    import imu_acc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    imu_acc_in_if.sink        i_in,
    imu_acc_out_if.source     o_out
);
    // programme control and the flags the jumps test
    t_ucode             w_ctrl;
    t_flags             w_flags;

    // shared divider
    t_div_req           w_div_req;
    logic               w_div_busy;
    logic signed [15:0] w_div_quot;

    // architectural state
    logic [15:0]          r_period;
    t_in_item             r_item;
    logic                 r_stage;
    logic [31:0]          r_pair_start;
    logic [31:0]          r_last_refresh;
    logic [31:0]          r_acc_sum [NUM_AXES];
    logic [31:0]          r_gyr_sum [NUM_AXES];
    logic [7:0]           r_acc_cnt;
    logic [7:0]           r_gyr_cnt;
    logic signed [15:0]   r_avg [NUM_AVG];
    logic [AVG_IDX_W-1:0] r_axis;

    // per-item result flags
    logic                 r_read_done;
    logic                 r_read_gyro;
    logic                 r_valid;

    // output register
    logic                 r_out_valid;
    t_out_item            r_out;

    // poll datapath
    logic [31:0] w_elapsed;
    logic        w_read;
    logic [7:0]  w_sel_cnt;
    logic        w_room;
    logic [31:0] w_sel_sum [NUM_AXES];
    logic [31:0] w_new_sum [NUM_AXES];
    logic        w_fresh;
    logic        w_out_full;
    logic        w_emit;

    assign w_fresh    = (r_acc_cnt != 8'd0) && (r_gyr_cnt != 8'd0);
    assign w_out_full = r_out_valid && !o_out.ready;
    assign w_emit     = (w_ctrl.op == OP_EMIT) && !w_out_full;

    assign w_flags = '{
        in_valid:  i_in.valid,
        is_fetch:  r_item.cmd,
        fresh:     w_fresh,
        div_busy:  w_div_busy,
        more_axes: r_axis != AVG_IDX_W'(NUM_AVG - 1),
        out_full:  w_out_full
    };

    imu_acc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // dividend picked by the axis pointer: first three accel, then gyro
    assign w_div_req.start    = (w_ctrl.op == OP_DIV_START);
    assign w_div_req.dividend = (r_axis < AVG_IDX_W'(NUM_AXES)) ? r_acc_sum[r_axis[1:0]]
                              : r_gyr_sum[2'(r_axis - AVG_IDX_W'(NUM_AXES))];
    assign w_div_req.divisor  = (r_axis < AVG_IDX_W'(NUM_AXES)) ? r_acc_cnt : r_gyr_cnt;

    imu_acc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    // read wanted on the gyro half, or once the wrapping elapsed time passes the period, if the bus is granted
    assign w_elapsed = r_item.time_us - r_pair_start;
    assign w_read    = (r_stage || (w_elapsed > {16'd0, r_period})) && r_item.bus_granted;
    assign w_sel_cnt = r_stage ? r_gyr_cnt : r_acc_cnt;
    assign w_room    = w_sel_cnt != COUNT_MAX;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            w_sel_sum[k] = r_stage ? r_gyr_sum[k] : r_acc_sum[k];
        end
        // axis remap: x from the second word, y from the first, z negated third
        w_new_sum[0] = w_sel_sum[0] + {{16{r_item.word_second[15]}}, r_item.word_second};
        w_new_sum[1] = w_sel_sum[1] + {{16{r_item.word_first[15]}}, r_item.word_first};
        w_new_sum[2] = w_sel_sum[2] - {{16{r_item.word_third[15]}}, r_item.word_third};
    end

    assign i_in.ready = (w_ctrl.op == OP_ACCEPT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= PERIOD_RESET;
            r_stage        <= 1'b0;
            r_pair_start   <= '0;
            r_last_refresh <= '0;
            r_acc_cnt      <= '0;
            r_gyr_cnt      <= '0;
            r_axis         <= '0;
            r_read_done    <= 1'b0;
            r_read_gyro    <= 1'b0;
            r_valid        <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_acc_sum[k] <= '0;
                r_gyr_sum[k] <= '0;
            end
            for (int k = 0; k < NUM_AVG; k++) begin
                r_avg[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end

            // result register drains on a transfer, refills on emit
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (w_ctrl.op)
                OP_ACCEPT: begin
                    if (i_in.valid) begin
                        r_item      <= i_in.data;
                        r_axis      <= '0;
                        r_read_done <= 1'b0;
                        r_read_gyro <= 1'b0;
                        r_valid     <= 1'b0;
                    end
                end
                OP_POLL: begin
                    if (w_read) begin
                        r_read_done <= 1'b1;
                        r_read_gyro <= r_stage;
                        // saturated count: the read still counts as done, words dropped
                        if (w_room) begin
                            for (int k = 0; k < NUM_AXES; k++) begin
                                if (r_stage) begin
                                    r_gyr_sum[k] <= w_new_sum[k];
                                end else begin
                                    r_acc_sum[k] <= w_new_sum[k];
                                end
                            end
                            if (r_stage) begin
                                r_gyr_cnt <= r_gyr_cnt + 8'd1;
                            end else begin
                                r_acc_cnt <= r_acc_cnt + 8'd1;
                            end
                        end
                        r_stage <= !r_stage;
                        // gyro read closes the pair and restarts the timer
                        if (r_stage) begin
                            r_pair_start <= r_item.time_us;
                        end
                    end
                end
                OP_STORE_AVG: begin
                    r_avg[r_axis] <= w_div_quot;
                    r_axis        <= r_axis + 1'b1;
                end
                OP_CLEAR: begin
                    for (int k = 0; k < NUM_AXES; k++) begin
                        r_acc_sum[k] <= '0;
                        r_gyr_sum[k] <= '0;
                    end
                    r_acc_cnt      <= '0;
                    r_gyr_cnt      <= '0;
                    r_last_refresh <= r_item.time_us;
                end
                OP_VALID: begin
                    r_valid <= (r_item.time_us - r_last_refresh) < VALID_WINDOW_US;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.read_done       <= r_read_done;
            r_out.read_was_gyro   <= r_read_gyro;
            r_out.accel_avg_x     <= r_avg[0];
            r_out.accel_avg_y     <= r_avg[1];
            r_out.accel_avg_z     <= r_avg[2];
            r_out.gyro_avg_x      <= r_avg[3];
            r_out.gyro_avg_y      <= r_avg[4];
            r_out.gyro_avg_z      <= r_avg[5];
            r_out.data_valid      <= r_valid;
            r_out.fresh_available <= w_fresh;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_accept_not_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_div_busy)
        else $error("input taken while the divider is running");

    a_store_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_STORE_AVG) |-> !w_div_busy)
        else $error("average stored before the quotient settled");

    a_read_excludes_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.read_done && r_out.data_valid))
        else $error("result flags both a poll read and a fetch validity");

    a_div_nonzero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> (w_div_req.divisor != 8'd0))
        else $error("division started with a zero count");
endmodule
